// ===== hw/rtl/dmf_pkg.sv =====
// Shared widths, defaults and controller/datapath interface types for the duplicate filter.
package dmf_pkg;

    // Field widths of one message and one result
    localparam int SRC_W     = 32;
    localparam int SER_W     = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Default table geometry
    localparam int SLOT_COUNT_DEF    = 16;
    localparam int HISTORY_DEPTH_DEF = 5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_load;      // capture the incoming transaction
        logic scan_start;   // read slot 0
        logic scan_next;    // read the following slot
        logic hit_capture;  // keep the row of the matching slot
        logic hist_next;    // step to the next ring entry
        logic hit_write;    // store the serial in the matching slot
        logic miss_read;    // advance the replace pointer and read that slot
        logic miss_write;   // take over the replaced slot
        logic set_dup;      // flag the message as a duplicate
        logic out_load;     // move the result into the output register
    } dmf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic src_match;    // row on the read port belongs to this source
        logic slot_last;    // row on the read port is the last slot
        logic ser_match;    // current ring entry equals the serial
        logic hist_last;    // current ring entry is the last one
        logic out_free;     // output register can take a result
    } dmf_sts_t;

endpackage

// ===== hw/rtl/duplicate_message_filter_top.sv =====
// Duplicate message filter: flags messages whose serial was recently seen from their source.
// The time from accept to m_tvalid depends on the slot scan through the single read
// port of the slot table, on the ring check and on the output register being free.
// One message at a time: the next is accepted once the result reaches the output
// register, which a result can enter only once the pending one has been taken.
// Reset: aresetn marks all slots unwritten (read as zero) and clears the replace pointer.
module duplicate_message_filter_top #(
    parameter int SLOT_COUNT    = dmf_pkg::SLOT_COUNT_DEF,
    parameter int HISTORY_DEPTH = dmf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dmf_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] source_id, [39:32] serial_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dmf_pkg::M_TDATA_W-1:0]   m_tdata   // [0] is_duplicate
);

    localparam int SRC_W = dmf_pkg::SRC_W;
    localparam int SER_W = dmf_pkg::SER_W;

    dmf_pkg::dmf_cmd_t cmd;
    dmf_pkg::dmf_sts_t sts;
    logic              out_is_duplicate;

    // Sequence one transaction through the table
    dmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, compare and output register
    dmf_dpath #(
        .SLOT_COUNT    (SLOT_COUNT),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_source_id     (s_tdata[SRC_W-1:0]),
        .in_serial_number (s_tdata[SRC_W +: SER_W]),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (m_tvalid),
        .out_is_duplicate (out_is_duplicate),
        .out_ready        (m_tready)
    );

    assign m_tdata = {{(dmf_pkg::M_TDATA_W - 1){1'b0}}, out_is_duplicate};

endmodule

// ===== hw/rtl/dmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dmf_ctrl.sv =====
// Controller state machine: sequences the slot scan, ring check and table update.
module dmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dmf_pkg::dmf_sts_t sts,
    output dmf_pkg::dmf_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_HIST    = 3'd2;
    localparam logic [2:0] ST_UPD     = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;
    localparam logic [2:0] ST_MISS_WR = 3'd5;
    localparam logic [2:0] ST_RESULT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (sts.src_match) begin
                    cmd.hit_capture = 1'b1;
                    state_next      = ST_HIST;
                end else if (sts.slot_last) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_HIST: begin
                priority if (sts.ser_match) begin
                    cmd.set_dup = 1'b1;
                    state_next  = ST_RESULT;
                end else if (sts.hist_last) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.hist_next = 1'b1;
                end
            end
            ST_UPD: begin
                cmd.hit_write = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_MISS: begin
                cmd.miss_read = 1'b1;
                state_next    = ST_MISS_WR;
            end
            ST_MISS_WR: begin
                cmd.miss_write = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted transaction always starts the slot scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN))
        else $error("accepted transaction did not start the scan");

endmodule

// ===== hw/rtl/dmf_dpath.sv =====
// Datapath: slot table RAM, message registers, ring compare and output register.
module dmf_dpath #(
    parameter int SLOT_COUNT    = dmf_pkg::SLOT_COUNT_DEF,
    parameter int HISTORY_DEPTH = dmf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [dmf_pkg::SRC_W-1:0]  in_source_id,
    input  logic [dmf_pkg::SER_W-1:0]  in_serial_number,
    input  dmf_pkg::dmf_cmd_t          cmd,
    output dmf_pkg::dmf_sts_t          sts,
    output logic                       out_valid,
    output logic                       out_is_duplicate,
    input  logic                       out_ready
);

    localparam int SRC_W    = dmf_pkg::SRC_W;
    localparam int SER_W    = dmf_pkg::SER_W;
    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_W   = SER_W * HISTORY_DEPTH;
    localparam int HIST_LSB = SRC_W;
    localparam int PTR_LSB  = SRC_W + HIST_W;
    localparam int ROW_W    = SRC_W + HIST_W + PTR_W;

    // Row layout, lowest bits first: source, ring entries 0..N-1, ring pointer
    logic [SRC_W-1:0]      src_reg;
    logic [SER_W-1:0]      ser_reg;
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic [SLOT_W-1:0]     rep_reg;
    logic [SLOT_W-1:0]     rep_next;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [PTR_W-1:0]      h_reg;
    logic                  dup_reg;
    logic                  out_valid_reg;
    logic                  out_dup_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_data;
    logic [ROW_W-1:0]  row_eff;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  upd_row;
    logic [ROW_W-1:0]  miss_row;
    logic [PTR_W-1:0]  cur_ptr;
    logic [PTR_W-1:0]  upd_ptr;
    logic [SER_W-1:0]  hist_entry [HISTORY_DEPTH];

    // Slot table
    dmf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (rd_slot_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Select the read address
    assign rep_next = (rep_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rep_reg + 1'b1;
    assign rd_en    = cmd.scan_start | cmd.scan_next | cmd.miss_read;

    always_comb begin
        priority if (cmd.scan_next) begin
            rd_addr = rd_slot_reg + 1'b1;
        end else if (cmd.miss_read) begin
            rd_addr = rep_next;
        end else begin
            rd_addr = '0;
        end
    end

    // A slot never written reads as all zero
    assign row_eff = valid_reg[rd_slot_reg] ? rd_data : '0;

    // Ring entries of the captured row
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_entry[i] = row_reg[HIST_LSB + SER_W * i +: SER_W];
        end
    end

    // Advance the ring pointer and store the serial at the new entry
    assign cur_ptr = row_reg[PTR_LSB +: PTR_W];
    assign upd_ptr = (cur_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : cur_ptr + 1'b1;

    always_comb begin
        upd_row = row_reg;
        upd_row[PTR_LSB +: PTR_W] = upd_ptr;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (PTR_W'(i) == upd_ptr) begin
                upd_row[HIST_LSB + SER_W * i +: SER_W] = ser_reg;
            end
        end
    end

    // Replaced slot: new source and ring entry 0, keep the rest
    always_comb begin
        miss_row = row_eff;
        miss_row[SRC_W-1:0] = src_reg;
        miss_row[HIST_LSB +: SER_W] = ser_reg;
    end

    assign wr_en   = cmd.hit_write | cmd.miss_write;
    assign wr_data = cmd.hit_write ? upd_row : miss_row;

    // Status toward the controller
    assign sts.src_match = (row_eff[SRC_W-1:0] == src_reg);
    assign sts.slot_last = (rd_slot_reg == SLOT_W'(SLOT_COUNT - 1));
    assign sts.ser_match = (hist_entry[h_reg] == ser_reg);
    assign sts.hist_last = (h_reg == PTR_W'(HISTORY_DEPTH - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Message, row and ring index registers
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            src_reg <= in_source_id;
            ser_reg <= in_serial_number;
        end
        if (rd_en) begin
            rd_slot_reg <= rd_addr;
        end
        if (cmd.hit_capture) begin
            row_reg <= row_eff;
        end
        if (cmd.hit_capture) begin
            h_reg <= '0;
        end else if (cmd.hist_next) begin
            h_reg <= h_reg + 1'b1;
        end
    end

    // Control state: replace pointer, written-slot marks, duplicate flag, output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg       <= '0;
            valid_reg     <= '0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.miss_read) begin
                rep_reg <= rep_next;
            end
            if (wr_en) begin
                valid_reg[rd_slot_reg] <= 1'b1;
            end
            if (cmd.in_load) begin
                dup_reg <= 1'b0;
            end else if (cmd.set_dup) begin
                dup_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_dup_reg <= dup_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_is_duplicate = out_dup_reg;

    // Table reads and writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("table read and write in the same cycle");

    // A written ring pointer stays inside the ring
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_data[PTR_LSB +: PTR_W] <= PTR_W'(HISTORY_DEPTH - 1)))
        else $error("ring pointer out of range");

    // A loaded result is not overwritten before it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_dup_reg)))
        else $error("pending result lost");

endmodule

// ===== dv/duplicate_message_filter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the duplicate message filter: directed cases plus random traffic.
module duplicate_message_filter_top_tb;

    localparam int SRC_W        = dmf_pkg::SRC_W;
    localparam int SER_W        = dmf_pkg::SER_W;
    localparam int S_TDATA_W    = dmf_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = dmf_pkg::M_TDATA_W;
    localparam int SLOTS        = dmf_pkg::SLOT_COUNT_DEF;
    localparam int DEPTH        = dmf_pkg::HISTORY_DEPTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + DEPTH + 3);
    localparam int MAX_POOL     = 32;
    localparam int MAX_PRINTS   = 40;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] source_id, [39:32] serial_number
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] is_duplicate, [7:1] zero

    // Shadow copy of the slot table
    logic [SRC_W-1:0] slot_owner [SLOTS];
    logic [SER_W-1:0] serial_ring [SLOTS][DEPTH];
    int unsigned      ring_pos [SLOTS];
    int unsigned      victim_slot;

    // Expected duplicate flags, oldest first
    bit          dup_flags_q [$];
    int unsigned errors;
    int unsigned messages_sent;
    int unsigned results_checked;
    int unsigned dups_seen;
    int unsigned idle_cycles;
    bit          no_idle;

    duplicate_message_filter_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Look up the source, flag a repeated serial, otherwise record it
    function automatic bit predict_duplicate(input logic [SRC_W-1:0] src,
                                             input logic [SER_W-1:0] ser);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_owner[s] == src) begin
                for (int h = 0; h < DEPTH; h++) begin
                    if (serial_ring[s][h] == ser) return 1'b1;
                end
                ring_pos[s] = (ring_pos[s] + 1) % DEPTH;
                serial_ring[s][ring_pos[s]] = ser;
                return 1'b0;
            end
        end
        // No owner found: take over the next slot, keeping its stale ring contents
        victim_slot = (victim_slot + 1) % SLOTS;
        slot_owner[victim_slot] = src;
        serial_ring[victim_slot][0] = ser;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic exp, input logic got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: expected %b, got %b", $time, what, exp, got);
    endtask

    // Drive one message; returns at the edge where the transaction is accepted
    task automatic send_message(input logic [SRC_W-1:0] src, input logic [SER_W-1:0] ser);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ser, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        dup_flags_q.push_back(predict_duplicate(src, ser));
        messages_sent++;
    endtask

    // Every slot starts as source 0 holding serial 0
    task automatic test_reset_contents();
        send_message(32'h0000_0000, 8'h00);
        send_message(32'h0000_0000, 8'hFF);
        send_message(32'h0000_0000, 8'hFF);
        send_message(32'h0000_0000, 8'h01);
    endtask

    // All-ones and alternating patterns; the first new source lands in slot 1
    task automatic test_field_extremes();
        send_message(32'hFFFF_FFFF, 8'hFF);
        send_message(32'hFFFF_FFFF, 8'hFF);
        // stale zeros left in the taken slot still count as seen
        send_message(32'hFFFF_FFFF, 8'h00);
        send_message(32'hFFFF_FFFF, 8'h80);
        send_message(32'hAAAA_AAAA, 8'h55);
        send_message(32'h5555_5555, 8'hAA);
        send_message(32'hAAAA_AAAA, 8'h55);
    endtask

    // Push six serials through one ring so the oldest is overwritten
    task automatic test_ring_wrap();
        for (int k = 1; k <= 6; k++)
            send_message(32'h1234_5678, 8'(k));
        send_message(32'h1234_5678, 8'h01);
        send_message(32'h1234_5678, 8'h06);
    endtask

    // Senders with rising serials, retransmissions, and some noise
    task automatic test_random_traffic(input int count, input int pool_size,
                                       input int quiet_from, input int quiet_to);
        logic [SRC_W-1:0] pool_src [MAX_POOL];
        logic [SER_W-1:0] pool_next [MAX_POOL];
        logic [SRC_W-1:0] src;
        logic [SER_W-1:0] ser;
        int               pick;
        int               dice;

        pool_src[0] = '0;
        pool_src[1] = '1;
        for (int p = 2; p < pool_size; p++)
            pool_src[p] = SRC_W'($urandom);
        for (int p = 0; p < pool_size; p++)
            pool_next[p] = SER_W'($urandom);

        for (int n = 0; n < count; n++) begin
            no_idle = (n >= quiet_from) && (n < quiet_to);
            pick = $urandom_range(0, pool_size - 1);
            dice = $urandom_range(0, 99);
            src  = pool_src[pick];
            if (dice < 60) begin
                ser = pool_next[pick];
                pool_next[pick] = pool_next[pick] + 1'b1;
            end else if (dice < 80) begin
                ser = pool_next[pick] - SER_W'($urandom_range(1, 7));
            end else if (dice < 90) begin
                ser = SER_W'($urandom);
            end else begin
                src = SRC_W'($urandom);
                ser = SER_W'($urandom);
            end
            send_message(src, ser);
        end
        no_idle = 1'b0;
    endtask

    // Receiver backpressure
    always @(posedge aclk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= 36);

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dup_flags_q.size() == 0) begin
                report_mismatch("unexpected result", 1'bx, m_tdata[0]);
            end else begin
                if (dup_flags_q[0]) dups_seen++;
                if (m_tdata[0] !== dup_flags_q[0])
                    report_mismatch("is_duplicate", dup_flags_q[0], m_tdata[0]);
                void'(dup_flags_q.pop_front());
                results_checked++;
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        no_idle  = 1'b0;
        messages_sent   = 0;
        victim_slot     = 0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_owner[s] = '0;
            ring_pos[s]   = 0;
            for (int h = 0; h < DEPTH; h++)
                serial_ring[s][h] = '0;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_contents();
        test_field_extremes();
        test_ring_wrap();
        test_random_traffic(500, 10, -1, -1);
        test_random_traffic(850, 24, 300, 500);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then give the block time for strays
        while (dup_flags_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d messages, checked %0d results, %0d expected duplicates.",
                 messages_sent, results_checked, dups_seen);
        $display("Covered reset contents, field extremes, ring wrap and slot churn; %0d errors.",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
